[rtl/acza_pkg.sv]
`timescale 1ns / 1ps

package acza_pkg;

  // Levels are signed dBFS in 1/16 dB steps
  localparam int unsigned LevelW = 12;
  localparam int unsigned TimeW = 16;
  localparam int unsigned MsW = 7;

  typedef logic signed [LevelW-1:0] level_t;
  typedef logic [TimeW-1:0] time_t;
  typedef logic [MsW-1:0] ms_t;
  typedef logic [1:0] zone_t;

  localparam level_t LEVEL_MIN = -12'sd2048;
  localparam level_t SP_YELLOW = -12'sd320;  // -20 dB
  localparam level_t SP_RED = -12'sd144;     // -9 dB
  localparam level_t TP_YELLOW = -12'sd208;  // -13 dB
  localparam level_t TP_RED = -12'sd32;      // -2 dB

  localparam ms_t ELAPSED_MAX = 7'd100;
  localparam time_t TIME_MAX = 16'hFFFF;

  localparam zone_t ZONE_NONE = 2'd0;
  localparam zone_t ZONE_GREEN = 2'd1;
  localparam zone_t ZONE_YELLOW = 2'd2;
  localparam zone_t ZONE_RED = 2'd3;

  // Control from the top level into one alert tracker
  typedef struct packed {
    logic step;   // advance the tracker by one frame
    logic clear;  // drop accumulated times, re-arm
  } trk_ctrl_t;

  function automatic zone_t zone_of(input logic seen, input level_t db, input logic tp_mode);
    level_t yellow;
    level_t red;
    yellow = tp_mode ? TP_YELLOW : SP_YELLOW;
    red = tp_mode ? TP_RED : SP_RED;
    if (!seen) begin
      zone_of = ZONE_NONE;
    end else if (db < yellow) begin
      zone_of = ZONE_GREEN;
    end else if (db < red) begin
      zone_of = ZONE_YELLOW;
    end else begin
      zone_of = ZONE_RED;
    end
  endfunction

endpackage

[rtl/audio_clip_zone_alert_core.sv]
`timescale 1ns / 1ps

// Peak zone meter with red-duration alerts.
//
// Input channel (in_valid / in_ready): one beat per audio channel, carrying
// the post-fader and pre-fader peaks with their valid flags. The beat with
// last_channel set closes the meter frame and also carries elapsed_ms.
// Output channel (out_valid / out_ready): one beat per closed frame with the
// frame maxima, their zones and the warning and alarm flags.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while the block is idle. Writing warnings_enabled re-arms both
// trackers. With meter_enabled low every input beat is taken and dropped.
//
// A last_channel beat lands in the input register when accepted. Its result
// goes to the result register, which drives out_valid, when the input
// register advances, which waits on a held, untaken result. One beat is
// taken per cycle while the result register is free or drains; between the two
// registers, maxima and trackers are combinational compares, saturating adds.
// Reset clears the running maxima, re-arms both trackers and loads the
// register defaults. When the receiver stalls, the result register holds
// its beat, the input register still fills, and in_ready falls only once
// both are occupied.

module audio_clip_zone_alert_core (
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [11:0]      out_peak_db,
  input  logic                    out_peak_valid,
  input  logic signed [11:0]      in_peak_db,
  input  logic                    in_peak_valid,
  input  logic                    last_channel,
  input  logic [6:0]              elapsed_ms,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [11:0]      out_level_db,
  output logic signed [11:0]      in_level_db,
  output logic [1:0]              out_zone,
  output logic [1:0]              in_zone,
  output logic                    out_warning_event,
  output logic                    in_warning_event,
  output logic                    out_alarm_active,
  output logic                    in_alarm_active
);
  import acza_pkg::*;

  localparam logic [2:0] REG_METER_EN = 3'd0;
  localparam logic [2:0] REG_PEAK_MODE = 3'd1;
  localparam logic [2:0] REG_WARN_EN = 3'd2;
  localparam logic [2:0] REG_IN_IGNORE = 3'd3;
  localparam logic [2:0] REG_WARN_MS = 3'd4;
  localparam logic [2:0] REG_RECOV_MS = 3'd5;

  // Configuration registers
  logic  meter_en;
  logic  peak_mode;
  logic  warn_en;
  logic  in_ignore;
  time_t warning_ms;
  time_t recovery_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      meter_en <= 1'b0;
      peak_mode <= 1'b0;
      warn_en <= 1'b1;
      in_ignore <= 1'b0;
      warning_ms <= 16'd1000;
      recovery_ms <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_METER_EN:  meter_en <= cfg_data[0];
        REG_PEAK_MODE: peak_mode <= cfg_data[0];
        REG_WARN_EN:   warn_en <= cfg_data[0];
        REG_IN_IGNORE: in_ignore <= cfg_data[0];
        REG_WARN_MS:   warning_ms <= cfg_data;
        REG_RECOV_MS:  recovery_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic   s1_valid;
  level_t s1_out_db;
  logic   s1_out_ok;
  level_t s1_in_db;
  logic   s1_in_ok;
  logic   s1_last;
  ms_t    s1_ms;

  logic advance;
  logic produce;
  logic res_valid;

  // Advance the input register whenever the result register is free or drains
  assign advance = s1_valid & (~res_valid | out_ready);
  assign in_ready = ~s1_valid | advance;
  assign produce = advance & s1_last & meter_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_out_db <= out_peak_db;
      s1_out_ok <= out_peak_valid;
      s1_in_db <= in_peak_db;
      s1_in_ok <= in_peak_valid;
      s1_last <= last_channel;
      s1_ms <= elapsed_ms;
    end
  end

  // Frame maxima; hold them while the meter is off
  level_t out_lvl;
  level_t in_lvl;
  logic   out_seen;
  logic   in_seen;

  acza_frame_max u_out_max (
    .clk        (clk),
    .rst        (rst),
    .upd        (advance & meter_en),
    .peak_db    (s1_out_db),
    .peak_valid (s1_out_ok),
    .last       (s1_last),
    .level      (out_lvl),
    .seen       (out_seen)
  );

  acza_frame_max u_in_max (
    .clk        (clk),
    .rst        (rst),
    .upd        (advance & meter_en),
    .peak_db    (s1_in_db),
    .peak_valid (s1_in_ok),
    .last       (s1_last),
    .level      (in_lvl),
    .seen       (in_seen)
  );

  zone_t oz;
  zone_t iz;
  ms_t   ms_clamped;

  assign oz = zone_of(out_seen, out_lvl, peak_mode);
  assign iz = zone_of(in_seen, in_lvl, peak_mode);
  assign ms_clamped = (s1_ms > ELAPSED_MAX) ? ELAPSED_MAX : s1_ms;

  // Trackers step per closed frame when enabled; a warnings_enabled write re-arms
  trk_ctrl_t out_ctrl;
  trk_ctrl_t in_ctrl;
  logic      trk_clear;
  logic      oev;
  logic      iev;
  logic      oact;
  logic      iact;

  assign trk_clear = cfg_we & (cfg_index == REG_WARN_EN);
  assign out_ctrl = '{step: produce & warn_en, clear: trk_clear};
  assign in_ctrl = '{step: produce & warn_en & ~in_ignore, clear: trk_clear};

  acza_tracker u_out_trk (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (out_ctrl),
    .zone        (oz),
    .ms          (ms_clamped),
    .warning_ms  (warning_ms),
    .recovery_ms (recovery_ms),
    .fired       (oev),
    .alarm       (oact)
  );

  acza_tracker u_in_trk (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (in_ctrl),
    .zone        (iz),
    .ms          (ms_clamped),
    .warning_ms  (warning_ms),
    .recovery_ms (recovery_ms),
    .fired       (iev),
    .alarm       (iact)
  );

  // Result register: load on a closed frame, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (produce) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_level_db <= out_lvl;
      in_level_db <= in_lvl;
      out_zone <= oz;
      in_zone <= iz;
      out_warning_event <= oev;
      in_warning_event <= iev;
      out_alarm_active <= oact;
      in_alarm_active <= iact;
    end
  end

  assign out_valid = res_valid;

endmodule

[rtl/acza_frame_max.sv]
`timescale 1ns / 1ps

module acza_frame_max (
  input  logic            clk,
  input  logic            rst,
  input  logic            upd,
  input  acza_pkg::level_t peak_db,
  input  logic            peak_valid,
  input  logic            last,
  output acza_pkg::level_t level,
  output logic            seen
);
  import acza_pkg::*;

  level_t run_max;
  logic   run_seen;
  level_t cur_max;

  // Fold in the current channel
  always_comb begin
    if (peak_valid && (!run_seen || peak_db > run_max)) begin
      cur_max = peak_db;
    end else begin
      cur_max = run_max;
    end
    seen = run_seen | peak_valid;
    level = seen ? cur_max : LEVEL_MIN;
  end

  // Clear at the end of each frame
  always_ff @(posedge clk) begin
    if (rst) begin
      run_max <= LEVEL_MIN;
      run_seen <= 1'b0;
    end else if (upd) begin
      if (last) begin
        run_max <= LEVEL_MIN;
        run_seen <= 1'b0;
      end else begin
        run_max <= cur_max;
        run_seen <= seen;
      end
    end
  end

endmodule

[rtl/acza_tracker.sv]
`timescale 1ns / 1ps

module acza_tracker (
  input  logic               clk,
  input  logic               rst,
  input  acza_pkg::trk_ctrl_t ctrl,
  input  acza_pkg::zone_t    zone,
  input  acza_pkg::ms_t      ms,
  input  acza_pkg::time_t    warning_ms,
  input  acza_pkg::time_t    recovery_ms,
  output logic               fired,
  output logic               alarm
);
  import acza_pkg::*;

  time_t red_time;
  time_t recover_time;
  logic  armed;

  time_t red_time_next;
  time_t recover_time_next;
  logic  armed_next;
  logic  fire;

  logic [TimeW:0] red_sum;
  logic [TimeW:0] rec_sum;
  time_t red_sat;
  time_t rec_sat;

  always_comb begin
    red_sum = {1'b0, red_time} + {{(TimeW+1-MsW){1'b0}}, ms};
    rec_sum = {1'b0, recover_time} + {{(TimeW+1-MsW){1'b0}}, ms};
    red_sat = red_sum[TimeW] ? TIME_MAX : red_sum[TimeW-1:0];
    rec_sat = rec_sum[TimeW] ? TIME_MAX : rec_sum[TimeW-1:0];

    red_time_next = red_time;
    recover_time_next = recover_time;
    armed_next = armed;
    fire = 1'b0;
    if (zone == ZONE_RED) begin
      red_time_next = red_sat;
      recover_time_next = '0;
      if (armed && red_sat >= warning_ms) begin
        fire = 1'b1;
        armed_next = 1'b0;
      end
    end else begin
      recover_time_next = rec_sat;
      if (rec_sat >= recovery_ms) begin
        red_time_next = '0;
        armed_next = 1'b1;
      end
    end

    fired = ctrl.step & fire;
    alarm = ctrl.step & ~armed_next & (zone == ZONE_RED);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      red_time <= '0;
      recover_time <= '0;
      armed <= 1'b1;
    end else if (ctrl.step) begin
      red_time <= red_time_next;
      recover_time <= recover_time_next;
      armed <= armed_next;
    end
  end

endmodule

[tb/tb_audio_clip_zone_alert_core.sv]
`timescale 1ns / 1ps

module tb_audio_clip_zone_alert_core;
  import acza_pkg::*;

  // Register map of the configuration port
  localparam logic [2:0] REG_METER_EN = 3'd0;
  localparam logic [2:0] REG_PEAK_MODE = 3'd1;
  localparam logic [2:0] REG_WARN_EN = 3'd2;
  localparam logic [2:0] REG_INPUT_IGNORED = 3'd3;
  localparam logic [2:0] REG_WARNING_MS = 3'd4;
  localparam logic [2:0] REG_RECOVERY_MS = 3'd5;
  localparam logic [2:0] REG_SPARE = 3'd6;  // 6 and 7 are unmapped

  localparam int DRAIN_CYCLES = 8;      // two-register pipeline plus margin
  localparam int RANDOM_ITEMS = 580;

  typedef struct {
    level_t out_db;
    logic   out_ok;
    level_t in_db;
    logic   in_ok;
    logic   last;
    ms_t    ms;
  } chan_beat_t;

  typedef struct {
    level_t out_lvl;
    level_t in_lvl;
    zone_t  out_z;
    zone_t  in_z;
    logic   out_warn;
    logic   in_warn;
    logic   out_alarm;
    logic   in_alarm;
  } frame_result_t;

  typedef struct {
    time_t red_ms;
    time_t calm_ms;
    logic  armed;
  } alert_t;

  logic clk;
  logic rst = 1'b1;

  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic signed [11:0] out_peak_db = '0;
  logic              out_peak_valid = 1'b0;
  logic signed [11:0] in_peak_db = '0;
  logic              in_peak_valid = 1'b0;
  logic              last_channel = 1'b0;
  logic [6:0]        elapsed_ms = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [11:0] out_level_db;
  logic signed [11:0] in_level_db;
  logic [1:0]        out_zone;
  logic [1:0]        in_zone;
  logic              out_warning_event;
  logic              in_warning_event;
  logic              out_alarm_active;
  logic              in_alarm_active;

  audio_clip_zone_alert_core u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_peak_db       (out_peak_db),
    .out_peak_valid    (out_peak_valid),
    .in_peak_db        (in_peak_db),
    .in_peak_valid     (in_peak_valid),
    .last_channel      (last_channel),
    .elapsed_ms        (elapsed_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_level_db      (out_level_db),
    .in_level_db       (in_level_db),
    .out_zone          (out_zone),
    .in_zone           (in_zone),
    .out_warning_event (out_warning_event),
    .in_warning_event  (in_warning_event),
    .out_alarm_active  (out_alarm_active),
    .in_alarm_active   (in_alarm_active)
  );

  // ---------------------------------------------------------------------------
  // Meter model: register shadow, running maxima and the two alert trackers
  // ---------------------------------------------------------------------------
  logic   m_meter_on = 1'b0;
  logic   m_true_peak = 1'b0;
  logic   m_warn_on = 1'b1;
  logic   m_in_muted = 1'b0;
  time_t  m_warn_ms = 16'd1000;
  time_t  m_recover_ms = 16'd1000;
  level_t out_max = LEVEL_MIN;
  level_t in_max = LEVEL_MIN;
  logic   out_any = 1'b0;
  logic   in_any = 1'b0;
  alert_t out_alert;
  alert_t in_alert;

  chan_beat_t    send_q[$];       // beats waiting for the driver
  frame_result_t frame_results[$]; // frame reports still owed by the block

  int err_count = 0;
  int random_sent = 0;
  int quiet_cycles = 0;

  task automatic rearm_alerts();
    out_alert.red_ms = '0;
    out_alert.calm_ms = '0;
    out_alert.armed = 1'b1;
    in_alert = out_alert;
  endtask

  // Append one beat to the driver's queue
  task automatic add_beat(input chan_beat_t b);
    send_q.insert(send_q.size(), b);
  endtask

  function automatic zone_t classify(input logic any, input level_t lvl);
    level_t yel;
    level_t red;
    yel = m_true_peak ? TP_YELLOW : SP_YELLOW;
    red = m_true_peak ? TP_RED : SP_RED;
    if (!any) return ZONE_NONE;
    if ($signed(lvl) < $signed(yel)) return ZONE_GREEN;
    if ($signed(lvl) < $signed(red)) return ZONE_YELLOW;
    return ZONE_RED;
  endfunction

  // Advance one tracker by a frame; times saturate rather than wrap
  function automatic alert_t advance_alert(input alert_t a, input zone_t z, input time_t ms,
                                           output logic fired);
    alert_t n;
    logic [16:0] sum;
    n = a;
    fired = 1'b0;
    if (z == ZONE_RED) begin
      sum = {1'b0, a.red_ms} + {1'b0, ms};
      n.red_ms = sum[16] ? TIME_MAX : sum[15:0];
      n.calm_ms = '0;
      if (a.armed && n.red_ms >= m_warn_ms) begin
        fired = 1'b1;
        n.armed = 1'b0;
      end
    end else begin
      sum = {1'b0, a.calm_ms} + {1'b0, ms};
      n.calm_ms = sum[16] ? TIME_MAX : sum[15:0];
      if (n.calm_ms >= m_recover_ms) begin
        n.red_ms = '0;
        n.armed = 1'b1;
      end
    end
    return n;
  endfunction

  // Fold one accepted channel beat into the model; queue a report on frame close
  task automatic absorb_beat(input chan_beat_t b);
    frame_result_t r;
    ms_t step;
    if (!m_meter_on) return;
    if (b.out_ok) begin
      if (!out_any || $signed(b.out_db) > $signed(out_max)) out_max = b.out_db;
      out_any = 1'b1;
    end
    if (b.in_ok) begin
      if (!in_any || $signed(b.in_db) > $signed(in_max)) in_max = b.in_db;
      in_any = 1'b1;
    end
    if (!b.last) return;
    step = (b.ms > ELAPSED_MAX) ? ELAPSED_MAX : b.ms;
    r.out_z = classify(out_any, out_max);
    r.in_z = classify(in_any, in_max);
    r.out_lvl = out_any ? out_max : LEVEL_MIN;
    r.in_lvl = in_any ? in_max : LEVEL_MIN;
    r.out_warn = 1'b0;
    r.in_warn = 1'b0;
    r.out_alarm = 1'b0;
    r.in_alarm = 1'b0;
    if (m_warn_on) begin
      if (!m_in_muted) begin
        in_alert = advance_alert(in_alert, r.in_z, {9'd0, step}, r.in_warn);
        r.in_alarm = !in_alert.armed && (r.in_z == ZONE_RED);
      end
      out_alert = advance_alert(out_alert, r.out_z, {9'd0, step}, r.out_warn);
      r.out_alarm = !out_alert.armed && (r.out_z == ZONE_RED);
    end
    frame_results.insert(frame_results.size(), r);
    out_max = LEVEL_MIN;
    in_max = LEVEL_MIN;
    out_any = 1'b0;
    in_any = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: present queued beats in bursts, idle for random gaps in between.
  // Hold valid and payload steady until the beat is taken.
  // ---------------------------------------------------------------------------
  chan_beat_t cur_beat;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) absorb_beat(cur_beat);
      if (in_valid && !in_ready) begin
        quiet_cycles = 0;  // hold the stalled beat
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
        quiet_cycles = in_valid ? 0 : quiet_cycles + 1;
      end else if (send_q.size() != 0) begin
        cur_beat = send_q.pop_front();
        out_peak_db <= cur_beat.out_db;
        out_peak_valid <= cur_beat.out_ok;
        in_peak_db <= cur_beat.in_db;
        in_peak_valid <= cur_beat.in_ok;
        last_channel <= cur_beat.last;
        elapsed_ms <= cur_beat.ms;
        in_valid <= 1'b1;
        quiet_cycles = 0;
        if (burst_left <= 1) begin
          // roughly a quarter of bursts run straight into the next
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
        quiet_cycles = in_valid ? 0 : quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: switch between always ready, coin flips, a sparse
  // periodic pattern and long stalls
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(40, 200);
      end else begin
        stall_left--;
      end
      stall_tick++;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (stall_tick % 3 == 0);
        default: out_ready <= (stall_tick % 11 < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every delivered frame report with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  frame_result_t want_r;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (frame_results.size() == 0) begin
        err_count++;
        $error("frame report delivered with none outstanding");
      end else begin
        want_r = frame_results.pop_front();
        check_field("out_level_db", int'(want_r.out_lvl), int'(out_level_db));
        check_field("in_level_db", int'(want_r.in_lvl), int'(in_level_db));
        check_field("out_zone", want_r.out_z, out_zone);
        check_field("in_zone", want_r.in_z, in_zone);
        check_field("out_warning_event", want_r.out_warn, out_warning_event);
        check_field("in_warning_event", want_r.in_warn, in_warning_event);
        check_field("out_alarm_active", want_r.out_alarm, out_alarm_active);
        check_field("in_alarm_active", want_r.in_alarm, in_alarm_active);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one register and mirror it in the model; the block takes it at the
  // next edge. Only call while the block is idle.
  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_METER_EN: m_meter_on = val[0];
      REG_PEAK_MODE: m_true_peak = val[0];
      REG_WARN_EN: begin
        m_warn_on = val[0];
        rearm_alerts();
      end
      REG_INPUT_IGNORED: m_in_muted = val[0];
      REG_WARNING_MS: m_warn_ms = val;
      REG_RECOVERY_MS: m_recover_ms = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Program every register; junk in the upper bits of the one-bit registers
  task automatic program_regs(input bit meter, input bit tp, input bit warn, input bit mute,
                              input logic [15:0] wms, input logic [15:0] rms);
    set_reg(REG_METER_EN, {15'($urandom), meter});
    set_reg(REG_PEAK_MODE, {15'($urandom), tp});
    set_reg(REG_WARN_EN, {15'($urandom), warn});
    set_reg(REG_INPUT_IGNORED, {15'($urandom), mute});
    set_reg(REG_WARNING_MS, wms);
    set_reg(REG_RECOVERY_MS, rms);
    if ($urandom_range(0, 1) == 1) set_reg(REG_SPARE + 3'($urandom_range(0, 1)), 16'($urandom));
    end_writes();
  endtask

  // Wait until every beat is taken, every report is in and the pipeline is empty
  task automatic wait_idle();
    while (send_q.size() != 0 || frame_results.size() != 0 || quiet_cycles < DRAIN_CYCLES)
      @(posedge clk);
  endtask

  function automatic chan_beat_t mk_beat(input int o, input bit ook, input int i, input bit iok,
                                         input bit last, input int ms);
    chan_beat_t b;
    b.out_db = level_t'(o);
    b.out_ok = ook;
    b.in_db = level_t'(i);
    b.in_ok = iok;
    b.last = last;
    b.ms = ms_t'(ms);
    return b;
  endfunction

  // Level biased towards the zone thresholds; hot makes red likely but not certain
  function automatic level_t pick_level(input bit hot);
    int yel;
    int red;
    int sel;
    int v;
    yel = m_true_peak ? int'(TP_YELLOW) : int'(SP_YELLOW);
    red = m_true_peak ? int'(TP_RED) : int'(SP_RED);
    sel = $urandom_range(0, 9);
    if (hot && sel < 6) sel = 9;
    case (sel)
      0: v = int'($urandom_range(0, 4095)) - 2048;
      1: begin
        case ($urandom_range(0, 4))
          0: v = -2048;
          1: v = 2047;
          2: v = 511;
          3: v = -1;
          default: v = 0;
        endcase
      end
      2, 3: begin
        case ($urandom_range(0, 3))
          0: v = int'(SP_YELLOW);
          1: v = int'(SP_RED);
          2: v = int'(TP_YELLOW);
          default: v = int'(TP_RED);
        endcase
        v = v + int'($urandom_range(0, 4)) - 2;
      end
      4, 5: v = int'($urandom_range(0, yel + 2047)) - 2048;
      6, 7: v = yel + int'($urandom_range(0, red - yel - 1));
      default: v = red + int'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 2047 - red
                                                                                : 511 - red));
    endcase
    return level_t'(v);
  endfunction

  // Elapsed time: mostly long steps so red builds up, some zero and over-range
  function automatic int pick_ms();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(101, 127);
      2: return $urandom_range(1, 49);
      default: return $urandom_range(50, 100);
    endcase
  endfunction

  // Queue a frame of nch channel beats; noisy frames carry few valid levels
  task automatic queue_frame(input int nch, input bit hot_o, input bit hot_i, input bit noisy);
    bit ook;
    bit iok;
    for (int k = 0; k < nch; k++) begin
      ook = noisy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
      iok = noisy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
      add_beat(mk_beat(pick_level(hot_o), ook, pick_level(hot_i), iok,
                       k == nch - 1, pick_ms()));
      random_sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    int quota;
    int run_left;
    int nch;
    bit hot_o;
    bit hot_i;
    bit paused;
    bit tp;
    bit warn;
    bit mute;
    logic [15:0] wms;
    logic [15:0] rms;

    rearm_alerts();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Meter is off after reset: these beats must vanish without a report
    add_beat(mk_beat(511, 1, 511, 1, 0, 100));
    add_beat(mk_beat(-5, 1, 0, 1, 0, 3));
    add_beat(mk_beat(200, 1, -2048, 1, 1, 100));
    wait_idle();

    // Directed frames under the reset defaults (sample peak, 1000 ms each way)
    set_reg(REG_METER_EN, 16'd1);
    end_writes();
    add_beat(mk_beat(-2048, 1, 2047, 1, 1, 0));     // field extremes
    add_beat(mk_beat(300, 0, -300, 0, 1, 100));     // frame with no valid level
    add_beat(mk_beat(-321, 1, -145, 1, 1, 10));     // just under each threshold
    add_beat(mk_beat(-320, 1, -144, 1, 1, 10));     // exactly on each threshold
    add_beat(mk_beat(-145, 1, -321, 1, 1, 10));
    add_beat(mk_beat(-144, 1, -320, 1, 1, 10));
    add_beat(mk_beat(100, 1, -500, 1, 0, 0));       // max sits mid-frame
    add_beat(mk_beat(400, 0, 300, 1, 0, 5));        // invalid level ignored
    add_beat(mk_beat(-50, 1, -600, 0, 1, 127));     // elapsed clamps to 100
    for (int k = 0; k < 11; k++)                    // red long enough to warn
      add_beat(mk_beat(511, 1, 511, 1, 1, (k % 3 == 0) ? 127 : 100));
    add_beat(mk_beat(-700, 1, -700, 1, 1, 100));
    wait_idle();

    // Running maxima survive a spell with the meter switched off
    add_beat(mk_beat(-100, 1, -400, 1, 0, 7));
    add_beat(mk_beat(-700, 1, 300, 0, 0, 7));
    wait_idle();
    set_reg(REG_METER_EN, 16'd0);
    end_writes();
    add_beat(mk_beat(500, 1, 500, 1, 0, 50));
    add_beat(mk_beat(510, 1, 510, 1, 1, 50));
    wait_idle();
    set_reg(REG_METER_EN, 16'd1);
    end_writes();
    add_beat(mk_beat(-900, 1, -1000, 1, 1, 60));
    wait_idle();

    // Random frames over a series of register settings, extremes first
    phase = 0;
    run_left = 0;
    hot_o = 0;
    hot_i = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin tp = 0; warn = 1; mute = 0; wms = 16'd300;   rms = 16'd200;   end
        1: begin tp = 1; warn = 1; mute = 0; wms = 16'd0;     rms = 16'd0;     end
        2: begin tp = 1; warn = 1; mute = 1; wms = 16'd150;   rms = 16'd400;   end
        3: begin tp = 0; warn = 0; mute = 0; wms = 16'd100;   rms = 16'd100;   end
        4: begin tp = 1; warn = 1; mute = 0; wms = 16'd60000; rms = 16'd60000; end
        5: begin tp = 0; warn = 1; mute = 1; wms = 16'hFFFF;  rms = 16'd0;     end
        default: begin
          tp = $urandom_range(0, 1);
          warn = ($urandom_range(0, 4) != 0);
          mute = ($urandom_range(0, 2) == 0);
          wms = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1000));
          rms = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1000));
        end
      endcase
      program_regs(1, tp, warn, mute, wms, rms);
      quota = random_sent + $urandom_range(50, 90);
      paused = 0;
      while (random_sent < quota) begin
        // runs of hot or cool frames so trackers both fire and recover
        if (run_left == 0) begin
          hot_o = $urandom_range(0, 1);
          hot_i = $urandom_range(0, 1);
          run_left = $urandom_range(2, 14);
        end
        run_left--;
        nch = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
        queue_frame(nch, hot_o, hot_i, $urandom_range(0, 9) == 0);
        // once, stop feeding mid-phase until every report has come back
        if (phase == 2 && !paused && random_sent >= quota - 40) begin
          paused = 1;
          wait_idle();
        end
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_results.size() != 0) begin
      err_count++;
      $error("%0d frame reports never delivered", frame_results.size());
    end
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
rtl/acza_pkg.sv
rtl/acza_frame_max.sv
rtl/acza_tracker.sv
rtl/audio_clip_zone_alert_core.sv
tb/tb_audio_clip_zone_alert_core.sv
